// ===== hw/rtl/ylle_pkg.sv =====
// ylle_pkg: shared widths, fixed-point coefficients and the log2 helper
// used by the luma log-enhance pipeline and its log ROM.
// No dependencies.
`timescale 1ns / 1ps

package ylle_pkg;

    // Pixel and register widths
    localparam int PIX_W  = 8;
    localparam int GAIN_W = 8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd30;

    // Default depth of the ln(1+Y) table
    localparam int LOG_TABLE_DEPTH_DEF = 1024;

    // Luma Y in unsigned Q8.8; chroma differences before scaling
    localparam int Y_W    = 16;
    localparam int DIFF_W = 17;
    // Scaled chroma difference product and the rounded Q9.8 chroma
    localparam int CPROD_W = 30;
    localparam int C_W     = 18;
    // ROM entries in Q3.13, gain product, channel products and sums
    localparam int ROM_W  = 16;
    localparam int T_W    = GAIN_W + ROM_W;
    localparam int P_W    = 34;
    localparam int SUM_W  = 36;
    localparam int FRAC_SHIFT = 22;
    localparam int ROUND_SHIFT = 12;

    // Forward luma weights (sum to 256)
    localparam logic [7:0] Y_R_K = 8'd77;
    localparam logic [7:0] Y_G_K = 8'd150;
    localparam logic [7:0] Y_B_K = 8'd29;

    // Chroma scales, Q.12
    localparam logic signed [12:0] CB_K = 13'sd2310;
    localparam logic signed [12:0] CR_K = 13'sd2920;

    // Inverse coefficients, Q2.14
    localparam logic signed [17:0] R_CR_K = 18'sd18675;
    localparam logic signed [17:0] G_CB_K = 18'sd6466;
    localparam logic signed [17:0] G_CR_K = 18'sd9513;
    localparam logic signed [17:0] B_CB_K = 18'sd33294;

    // ln2 in Q0.32
    localparam logic [63:0] LN2_Q32 = 64'd2977044472;

    // Base-2 log with 24 fraction bits by repeated squaring (elaboration only)
    function automatic logic [63:0] f_log2_q24(input logic [31:0] n);
        logic [63:0] k;
        logic [63:0] m;
        logic [63:0] frac;
        k    = '0;
        frac = '0;
        if (n == '0) begin
            return '0;
        end
        for (int j = 0; j < 31; j++) begin
            if ((n >> (j + 1)) != '0) begin
                k = 64'(j + 1);
            end
        end
        m = ({32'd0, n} << 30) >> k;
        for (int b = 23; b >= 0; b--) begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac[b] = 1'b1;
            end
        end
        return (k << 24) | frac;
    endfunction

    // Round a Q.12 product to an integer, half away from zero
    function automatic logic signed [C_W-1:0] f_round12(input logic signed [CPROD_W-1:0] v);
        logic [CPROD_W-1:0] mag;
        logic [CPROD_W-1:0] r;
        mag = v[CPROD_W-1] ? CPROD_W'(-v) : CPROD_W'(v);
        r   = (mag + (CPROD_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
        return v[CPROD_W-1] ? -C_W'(signed'(r)) : C_W'(signed'(r));
    endfunction

    // Clamp a Q.22 channel sum to a byte, dropping the fraction
    function automatic logic [PIX_W-1:0] f_to_byte(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] q;
        q = v >>> FRAC_SHIFT;
        if (v[SUM_W-1]) begin
            return '0;
        end
        if (q > SUM_W'(255)) begin
            return 8'd255;
        end
        return q[PIX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/ylle_log_rom.sv =====
// ylle_log_rom: ln(1 + 256*i/DEPTH) table in Q3.13 with a registered read.
// Contents are built at elaboration from ylle_pkg::f_log2_q24.
`timescale 1ns / 1ps

module ylle_log_rom #(
    parameter int LOG_TABLE_DEPTH = ylle_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [$clog2(LOG_TABLE_DEPTH)-1:0] i_addr,
    output logic [ylle_pkg::ROM_W-1:0]         o_data
);

    typedef logic [ylle_pkg::ROM_W-1:0] t_rom [LOG_TABLE_DEPTH];

    // Table entry i: (log2(DEPTH + 256*i) - log2(DEPTH)) * ln2, rounded to Q.13
    function automatic t_rom f_build_rom();
        t_rom        rom;
        logic [63:0] base;
        logic [63:0] num;
        logic [63:0] d;
        base = ylle_pkg::f_log2_q24(32'(LOG_TABLE_DEPTH));
        for (int i = 0; i < LOG_TABLE_DEPTH; i++) begin
            num    = 64'(LOG_TABLE_DEPTH) + 64'(256 * i);
            d      = ylle_pkg::f_log2_q24(num[31:0]) - base;
            rom[i] = ylle_pkg::ROM_W'((d * ylle_pkg::LN2_Q32 + (64'd1 << 42)) >> 43);
        end
        return rom;
    endfunction

    localparam t_rom LOG_ROM = f_build_rom();

    logic [ylle_pkg::ROM_W-1:0] r_data;

    // Synchronous read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= LOG_ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/ycbcr_log_luma_enhance.sv =====
// ycbcr_log_luma_enhance: four-stage pipeline, RGB -> Y/Cb/Cr, Y -> gain*ln(1+Y), back to RGB.
// Each item passes through the stage registers in order; one item per cycle sustained while i_ready stays high.
// The stages are: luma/differences, chroma rounding + log ROM read, gain and
// coefficient products, channel sums and clamp. A stage stalls only when full and blocked.
// Reset (synchronous, active low) empties the pipeline and sets gain to 30.
// Depends on ylle_pkg and ylle_log_rom.
`timescale 1ns / 1ps

module ycbcr_log_luma_enhance #(
    parameter int LOG_TABLE_DEPTH = ylle_pkg::LOG_TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // gain register
    input  logic                        i_gain_we,
    input  logic [ylle_pkg::GAIN_W-1:0] i_gain,
    // input items
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ylle_pkg::PIX_W-1:0]  i_red_in,
    input  logic [ylle_pkg::PIX_W-1:0]  i_green_in,
    input  logic [ylle_pkg::PIX_W-1:0]  i_blue_in,
    input  logic                        i_last_pixel,
    // result items
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ylle_pkg::PIX_W-1:0]  o_red_out,
    output logic [ylle_pkg::PIX_W-1:0]  o_green_out,
    output logic [ylle_pkg::PIX_W-1:0]  o_blue_out,
    output logic                        o_last_out
);

    localparam int IDX_W  = $clog2(LOG_TABLE_DEPTH);
    localparam int IDXM_W = ylle_pkg::Y_W + $clog2(LOG_TABLE_DEPTH + 1);

    // Gain register
    logic [ylle_pkg::GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= ylle_pkg::GAIN_RESET;
        end else if (i_gain_we) begin
            r_gain <= i_gain;
        end
    end

    // Stage valids and load enables
    logic r_vld1, r_vld2, r_vld3, r_vld4;
    logic rdy1, rdy2, rdy3, rdy4;
    logic ld1, ld2, ld3, ld4;

    assign rdy4 = !r_vld4 || i_ready;
    assign rdy3 = !r_vld3 || rdy4;
    assign rdy2 = !r_vld2 || rdy3;
    assign rdy1 = !r_vld1 || rdy2;
    assign ld1  = rdy1 && i_valid;
    assign ld2  = rdy2 && r_vld1;
    assign ld3  = rdy3 && r_vld2;
    assign ld4  = rdy4 && r_vld3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_vld1 <= i_valid;
            end
            if (rdy2) begin
                r_vld2 <= r_vld1;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
            if (rdy4) begin
                r_vld4 <= r_vld3;
            end
        end
    end

    // Stage 1: luma and chroma differences
    logic [ylle_pkg::Y_W-1:0]           n_y1,  r_y1;
    logic signed [ylle_pkg::DIFF_W-1:0] n_db1, r_db1;
    logic signed [ylle_pkg::DIFF_W-1:0] n_dr1, r_dr1;
    logic                               r_last1;

    always_comb begin
        n_y1  = ylle_pkg::Y_W'(ylle_pkg::Y_R_K * ylle_pkg::Y_W'(i_red_in))
              + ylle_pkg::Y_W'(ylle_pkg::Y_G_K * ylle_pkg::Y_W'(i_green_in))
              + ylle_pkg::Y_W'(ylle_pkg::Y_B_K * ylle_pkg::Y_W'(i_blue_in));
        n_db1 = signed'({1'b0, i_blue_in, 8'd0}) - signed'({1'b0, n_y1});
        n_dr1 = signed'({1'b0, i_red_in, 8'd0})  - signed'({1'b0, n_y1});
    end

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r_y1    <= n_y1;
            r_db1   <= n_db1;
            r_dr1   <= n_dr1;
            r_last1 <= i_last_pixel;
        end
    end

    // Stage 2: rounded chroma, log ROM address and read
    logic [IDXM_W-1:0]                  idx_full;
    logic [IDX_W-1:0]                   rom_addr;
    logic [ylle_pkg::ROM_W-1:0]         rom_q2;
    logic signed [ylle_pkg::C_W-1:0]    n_cb2, r_cb2;
    logic signed [ylle_pkg::C_W-1:0]    n_cr2, r_cr2;
    logic                               r_last2;

    always_comb begin
        idx_full = (IDXM_W'(r_y1) * IDXM_W'(LOG_TABLE_DEPTH)) >> ylle_pkg::Y_W;
        if (idx_full >= IDXM_W'(LOG_TABLE_DEPTH)) begin
            rom_addr = IDX_W'(LOG_TABLE_DEPTH - 1);
        end else begin
            rom_addr = idx_full[IDX_W-1:0];
        end
        n_cb2 = ylle_pkg::f_round12(ylle_pkg::CPROD_W'(r_db1)
                                    * ylle_pkg::CPROD_W'(ylle_pkg::CB_K));
        n_cr2 = ylle_pkg::f_round12(ylle_pkg::CPROD_W'(r_dr1)
                                    * ylle_pkg::CPROD_W'(ylle_pkg::CR_K));
    end

    ylle_log_rom #(
        .LOG_TABLE_DEPTH(LOG_TABLE_DEPTH)
    ) u_log_rom (
        .i_clk (i_clk),
        .i_en  (ld2),
        .i_addr(rom_addr),
        .o_data(rom_q2)
    );

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r_cb2   <= n_cb2;
            r_cr2   <= n_cr2;
            r_last2 <= r_last1;
        end
    end

    // Stage 3: gain times log, coefficient products
    logic [ylle_pkg::T_W-1:0]        n_t3, r_t3;
    logic signed [ylle_pkg::P_W-1:0] n_prc3, r_prc3;
    logic signed [ylle_pkg::P_W-1:0] n_pgb3, r_pgb3;
    logic signed [ylle_pkg::P_W-1:0] n_pgr3, r_pgr3;
    logic signed [ylle_pkg::P_W-1:0] n_pbb3, r_pbb3;
    logic                            r_last3;

    always_comb begin
        n_t3   = ylle_pkg::T_W'(r_gain) * ylle_pkg::T_W'(rom_q2);
        n_prc3 = ylle_pkg::P_W'(r_cr2) * ylle_pkg::P_W'(ylle_pkg::R_CR_K);
        n_pgb3 = ylle_pkg::P_W'(r_cb2) * ylle_pkg::P_W'(ylle_pkg::G_CB_K);
        n_pgr3 = ylle_pkg::P_W'(r_cr2) * ylle_pkg::P_W'(ylle_pkg::G_CR_K);
        n_pbb3 = ylle_pkg::P_W'(r_cb2) * ylle_pkg::P_W'(ylle_pkg::B_CB_K);
    end

    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r_t3    <= n_t3;
            r_prc3  <= n_prc3;
            r_pgb3  <= n_pgb3;
            r_pgr3  <= n_pgr3;
            r_pbb3  <= n_pbb3;
            r_last3 <= r_last2;
        end
    end

    // Stage 4: channel sums in Q.22, clamp to bytes
    logic signed [ylle_pkg::SUM_W-1:0] t_ext;
    logic signed [ylle_pkg::SUM_W-1:0] sum_r, sum_g, sum_b;
    logic [ylle_pkg::PIX_W-1:0]        n_r4, n_g4, n_b4;
    logic [ylle_pkg::PIX_W-1:0]        r_r4, r_g4, r_b4;
    logic                              r_last4;

    always_comb begin
        t_ext = signed'(ylle_pkg::SUM_W'({r_t3, 9'd0}));
        sum_r = t_ext + ylle_pkg::SUM_W'(r_prc3);
        sum_g = t_ext - ylle_pkg::SUM_W'(r_pgb3) - ylle_pkg::SUM_W'(r_pgr3);
        sum_b = t_ext + ylle_pkg::SUM_W'(r_pbb3);
        n_r4  = ylle_pkg::f_to_byte(sum_r);
        n_g4  = ylle_pkg::f_to_byte(sum_g);
        n_b4  = ylle_pkg::f_to_byte(sum_b);
    end

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_r4    <= n_r4;
            r_g4    <= n_g4;
            r_b4    <= n_b4;
            r_last4 <= r_last3;
        end
    end

    assign o_ready     = rdy1;
    assign o_valid     = r_vld4;
    assign o_red_out   = r_r4;
    assign o_green_out = r_g4;
    assign o_blue_out  = r_b4;
    assign o_last_out  = r_last4;

endmodule

// ===== hw/rtl/ylle_checker.sv =====
// ylle_checker: port-level assertions for ycbcr_log_luma_enhance.
// Bound to the top level at the end of this file; uses ylle_pkg widths.
`timescale 1ns / 1ps

module ylle_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_ready,
    input logic                       i_last_pixel,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [ylle_pkg::PIX_W-1:0] o_red_out,
    input logic [ylle_pkg::PIX_W-1:0] o_green_out,
    input logic [ylle_pkg::PIX_W-1:0] o_blue_out,
    input logic                       o_last_out
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Empty output stage means the whole pipeline can take an item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("not ready while output stage is empty");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_red_out) && $stable(o_green_out)
                                && $stable(o_blue_out) && $stable(o_last_out))
        else $error("stalled result changed");

    // Without back-pressure an accepted item comes out with its last flag intact
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready
        |=> o_valid && (o_last_out == $past(i_last_pixel, 4)))
        else $error("item missing or flag wrong at fixed latency");

endmodule

bind ycbcr_log_luma_enhance ylle_checker u_ylle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_last_pixel(i_last_pixel),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red_out   (o_red_out),
    .o_green_out (o_green_out),
    .o_blue_out  (o_blue_out),
    .o_last_out  (o_last_out)
);
